FILE: rtl/irut_pkg.sv
package irut_pkg;

    // Item kind, carried on tuser of the slave side
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
    } t_item;

    // Packed LSB first: pin_level, busy_res, accepted
    typedef struct packed {
        logic accepted;
        logic busy_res;
        logic pin_level;
    } t_result;

    // Queue to back end handshake
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    localparam int ADDR_W = 4;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_BIT_TICKS        = 2'd0;
    localparam logic [1:0] REG_CARRIER_TICKS    = 2'd1;
    localparam logic [1:0] REG_CARRIER_ON_TICKS = 2'd2;

    localparam logic [15:0] BIT_TICKS_RST        = 16'd416;
    localparam logic [7:0]  CARRIER_TICKS_RST    = 8'd26;
    localparam logic [7:0]  CARRIER_ON_TICKS_RST = 8'd9;

endpackage

FILE: rtl/ir_carrier_uart_transmitter.sv
// Channel     | Dir | Signals                          | Payload
// ------------+-----+----------------------------------+--------------------------------
// s_axis      | in  | tvalid tready tdata[7:0] tuser   | tdata: byte_value; tuser: mode
// m_axis      | out | tvalid tready tdata[7:0]         | pin_level, busy_res, accepted
// apb         | in  | psel penable pwrite paddr[3:0]   | bit_ticks, carrier_ticks,
//             |     | pwdata prdata pready             | carrier_on_ticks at 0x0/0x4/0x8
//
// One item per clock cycle sustained while m_axis does not stall; an item's result reaches
// m_axis through the queue entry and then the result register.
// The transmitter state update in the back end is a combinational step ahead of its registers, which sets the rate.
// Reset is synchronous, active low; it empties the queue and returns the frame to idle.
// A stall on m_axis holds the result register; the two-entry queue keeps taking
// items until it is full, then s_axis tready drops.
module ir_carrier_uart_transmitter #(
    parameter int DATA_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  logic        i_s_axis_tuser,   // [0] mode
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] pin_level [1] busy_res [2] accepted, rest 0
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [irut_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [15:0] r_bit_ticks;
    logic [7:0]  r_carrier_ticks;
    logic [7:0]  r_carrier_on_ticks;
    logic        cfg_wr;
    logic [1:0]  reg_idx;

    irut_pkg::t_queue_head head;
    logic                  pop;
    irut_pkg::t_result     result;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[3:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    // Config registers; software must write them only while no item is in flight, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks        <= irut_pkg::BIT_TICKS_RST;
            r_carrier_ticks    <= irut_pkg::CARRIER_TICKS_RST;
            r_carrier_on_ticks <= irut_pkg::CARRIER_ON_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                irut_pkg::REG_BIT_TICKS:        r_bit_ticks        <= i_pwdata[15:0];
                irut_pkg::REG_CARRIER_TICKS:    r_carrier_ticks    <= i_pwdata[7:0];
                irut_pkg::REG_CARRIER_ON_TICKS: r_carrier_on_ticks <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            irut_pkg::REG_BIT_TICKS:        o_prdata = {16'd0, r_bit_ticks};
            irut_pkg::REG_CARRIER_TICKS:    o_prdata = {24'd0, r_carrier_ticks};
            irut_pkg::REG_CARRIER_ON_TICKS: o_prdata = {24'd0, r_carrier_on_ticks};
            default:                        o_prdata = 32'd0;
        endcase
    end

    // Front end: take and classify items into the queue
    irut_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_user  (i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Back end: frame sequencing, carrier timing and the result register
    irut_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head),
        .o_pop              (pop),
        .i_bit_ticks        (r_bit_ticks),
        .i_carrier_ticks    (r_carrier_ticks),
        .i_carrier_on_ticks (r_carrier_on_ticks),
        .o_valid            (o_m_axis_tvalid),
        .i_ready            (i_m_axis_tready),
        .o_result           (result)
    );

    assign o_m_axis_tdata = {5'd0, result};

endmodule

FILE: rtl/irut_front.sv
module irut_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_user,
    input  logic [7:0]           i_data,
    output irut_pkg::t_queue_head o_head,
    input  logic                 i_pop
);

    // Two-entry queue between the input handshake and the transmitter
    irut_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    logic            pop;
    irut_pkg::t_item in_item;

    always_comb begin
        in_item.kind       = irut_pkg::t_kind'(i_user);
        in_item.byte_value = i_data;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");

endmodule

FILE: rtl/irut_back.sv
module irut_back #(
    parameter int DATA_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  irut_pkg::t_queue_head i_head,
    output logic                  o_pop,
    input  logic [15:0]           i_bit_ticks,
    input  logic [7:0]            i_carrier_ticks,
    input  logic [7:0]            i_carrier_on_ticks,
    output logic                  o_valid,
    input  logic                  i_ready,
    output irut_pkg::t_result     o_result
);

    localparam logic [3:0] LAST_POS = 4'(DATA_BITS + 1);
    localparam logic [3:0] DATA_POS = 4'(DATA_BITS);

    logic [7:0]  r_shift,  n_shift;
    logic [3:0]  r_pos,    n_pos;
    logic [15:0] r_bt,     n_bt;
    logic [7:0]  r_ct,     n_ct;
    logic        r_sending, n_sending;
    logic        r_valid;
    irut_pkg::t_result r_res, n_res;

    logic        take;
    logic        burst;
    logic [3:0]  idx;
    logic [3:0]  pos_inc;
    logic [15:0] bt_inc;
    logic [7:0]  ct_inc;

    // Output register frees when empty or being drained
    assign take  = i_head.valid && (!r_valid || i_ready);
    assign o_pop = take;

    assign idx     = r_pos - 4'd1;
    assign pos_inc = r_pos + 4'd1;
    assign bt_inc  = r_bt + 16'd1;
    assign ct_inc  = r_ct + 8'd1;

    always_comb begin
        if (r_pos == 4'd0) begin
            burst = 1'b1;
        end else if (r_pos > DATA_POS || idx[3]) begin
            burst = 1'b0;
        end else begin
            burst = !r_shift[idx[2:0]];
        end
    end

    always_comb begin
        n_shift   = r_shift;
        n_pos     = r_pos;
        n_bt      = r_bt;
        n_ct      = r_ct;
        n_sending = r_sending;
        n_res.pin_level = 1'b1;
        n_res.busy_res  = r_sending;
        n_res.accepted  = 1'b0;
        unique case (i_head.item.kind)
            irut_pkg::KIND_LOAD: begin
                if (!r_sending) begin
                    n_shift        = i_head.item.byte_value;
                    n_pos          = 4'd0;
                    n_bt           = 16'd0;
                    n_ct           = 8'd0;
                    n_sending      = 1'b1;
                    n_res.accepted = 1'b1;
                    n_res.busy_res = 1'b1;
                end
            end
            irut_pkg::KIND_TICK: begin
                if (r_sending) begin
                    if (burst) begin
                        n_res.pin_level = !(r_ct < i_carrier_on_ticks);
                    end
                    n_ct = (ct_inc >= i_carrier_ticks) ? 8'd0 : ct_inc;
                    n_bt = bt_inc;
                    // bit boundary; a zero length bit ends after one tick
                    if (bt_inc >= i_bit_ticks || bt_inc == 16'd0) begin
                        n_bt  = 16'd0;
                        n_ct  = 8'd0;
                        n_pos = pos_inc;
                        if (pos_inc > LAST_POS) begin
                            n_pos     = 4'd0;
                            n_sending = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= 8'd0;
            r_pos     <= 4'd0;
            r_bt      <= 16'd0;
            r_ct      <= 8'd0;
            r_sending <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (take) begin
                r_shift   <= n_shift;
                r_pos     <= n_pos;
                r_bt      <= n_bt;
                r_ct      <= n_ct;
                r_sending <= n_sending;
                r_valid   <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_pos == 4'd0 && r_bt == 16'd0 && r_ct == 8'd0))
        else $error("idle with stale frame state");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS) else $error("bit position past stop bit");
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.accepted) |-> r_res.busy_res)
        else $error("accepted load not reported busy");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> ($stable(r_res) && r_valid))
        else $error("stalled result changed");

endmodule
